// ===== hdl/relr_pkg.sv =====
// Shared constants and controller/datapath interface types for the RELR decoder.
// No dependencies; imported by every module of the block.
package relr_pkg;

  localparam int ADDR_W      = 64;
  localparam int ENTRY_W     = 64;
  localparam int BITMAP_BITS = 63;
  localparam int IDX_W       = $clog2(BITMAP_BITS);
  localparam int WORD_SHIFT  = 3;
  localparam logic [ADDR_W-1:0] WORD_BYTES    = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] BITMAP_STRIDE = ADDR_W'(8 * BITMAP_BITS);

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [BITMAP_BITS-1:0] bitmap_t;

  typedef struct packed {
    logic capture;   // latch a new entry
    logic emit;      // load one result into the output register
    logic finish;    // update the next-word address, entry done
  } relr_cmd_t;

  typedef struct packed {
    logic is_bitmap; // held entry is a bitmap
    logic bits_left; // bitmap still has set bits
    logic one_left;  // at most one set bit remains
    logic out_free;  // output register can take a result this cycle
  } relr_stat_t;

endpackage

// ===== hdl/relr_datapath.sv =====
// Datapath: load base, next-word address, held entry, bitmap scan and output register.
// Depends on relr_pkg; driven by relr_ctrl through relr_cmd_t.
module relr_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [relr_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic [relr_pkg::ENTRY_W-1:0]  in_packed_entry,
  input  logic                          in_end_of_table,
  input  relr_pkg::relr_cmd_t           cmd,
  output relr_pkg::relr_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [relr_pkg::ADDR_W-1:0]   out_patch_address,
  output logic                          out_last_of_item
);
  import relr_pkg::*;

  addr_t         load_base_r;
  addr_t         next_addr_r;
  addr_t         work_r;
  bitmap_t       bitmap_r;
  logic          is_bitmap_r;
  logic          end_r;
  logic          out_valid_r;
  addr_t         out_addr_r;
  logic          out_last_r;

  bitmap_t       low_bit;
  bitmap_t       rest;
  logic [IDX_W-1:0] idx;
  addr_t         emit_addr;
  addr_t         next_addr_nxt;

  // Isolate the lowest set bit and encode its position.
  always_comb begin
    low_bit = bitmap_r & (~bitmap_r + BITMAP_BITS'(1));
    rest    = bitmap_r & ~low_bit;
    idx     = '0;
    for (int j = 0; j < BITMAP_BITS; j++) begin
      if (low_bit[j]) idx = idx | IDX_W'(j);
    end
    emit_addr = is_bitmap_r
              ? work_r + {{(ADDR_W-IDX_W-WORD_SHIFT){1'b0}}, idx, {WORD_SHIFT{1'b0}}}
              : work_r;
    if (end_r) begin
      next_addr_nxt = '0;
    end else if (is_bitmap_r) begin
      next_addr_nxt = work_r + BITMAP_STRIDE;
    end else begin
      next_addr_nxt = work_r + WORD_BYTES;
    end
  end

  always_comb begin
    stat.is_bitmap = is_bitmap_r;
    stat.bits_left = |bitmap_r;
    stat.one_left  = ~|rest;
    stat.out_free  = ~out_valid_r | out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= '0;
      next_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) load_base_r <= cfg_wdata;
      if (cmd.finish) next_addr_r <= next_addr_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_bitmap_r <= in_packed_entry[0];
      end_r       <= in_end_of_table;
      bitmap_r    <= in_packed_entry[ENTRY_W-1:1];
      work_r      <= in_packed_entry[0] ? next_addr_r : load_base_r + in_packed_entry;
    end else if (cmd.emit) begin
      bitmap_r <= rest;
    end
    if (cmd.emit) begin
      out_addr_r <= emit_addr;
      out_last_r <= is_bitmap_r ? ~|rest : 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_patch_address = out_addr_r;
  assign out_last_of_item  = out_last_r;

endmodule

// ===== hdl/relr_ctrl.sv =====
// Controller: accepts one entry, then steps the datapath through its results.
// Depends on relr_pkg; drives relr_datapath through relr_cmd_t.
module relr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  relr_pkg::relr_stat_t  stat,
  output relr_pkg::relr_cmd_t   cmd
);
  import relr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.is_bitmap) begin
          if (stat.out_free) begin
            cmd.emit   = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else if (!stat.bits_left) begin
          // empty bitmap: advance only
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.one_left) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/relr_relocation_decoder.sv =====
// Top level of the RELR relative-relocation decoder: controller plus datapath.
// Depends on relr_pkg, relr_ctrl and relr_datapath.
//
//  channel  signals                                  direction
//  input    in_valid/in_ready, in_packed_entry,      in
//           in_end_of_table
//  result   out_valid/out_ready, out_patch_address,  out
//           out_last_of_item
//  config   cfg_we, cfg_wdata (load base)            in
//
// An entry is accepted in the idle state; its results then follow at one result per cycle
// while the output register is free (offset: one, bitmap: one per set bit, empty bitmap:
// none). Reset (rst_n low, synchronous) clears load base, next-word address, the output
// valid flag and controller state. A stalled output holds the scan in place; a new entry
// is taken while the last result of the previous one waits.
module relr_relocation_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [relr_pkg::ADDR_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [relr_pkg::ENTRY_W-1:0]  in_packed_entry,
  input  logic                          in_end_of_table,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [relr_pkg::ADDR_W-1:0]   out_patch_address,
  output logic                          out_last_of_item
);
  import relr_pkg::*;

  relr_cmd_t  cmd;
  relr_stat_t stat;

  relr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  relr_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_packed_entry   (in_packed_entry),
    .in_end_of_table   (in_end_of_table),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_patch_address (out_patch_address),
    .out_last_of_item  (out_last_of_item)
  );

  // A transfer in always starts a busy phase.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // Never emit while a result is stuck in the output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // Emitting the final result of an entry always finishes it.
  a_last_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && (!stat.is_bitmap || stat.one_left) |-> cmd.finish)
    else $error("last result without finish");

  // Out of reset the block is idle with nothing pending.
  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

// ===== sim/tb_relr_relocation_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for relr_relocation_decoder: directed and random RELR tables with
// an in-order patch predictor, random sender gaps, receiver stalls and one long output hold-off.
// Depends on relr_pkg and the relr_relocation_decoder RTL.
module tb_relr_relocation_decoder;
  import relr_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 135;
  localparam int MAX_REPORTS   = 200;
  localparam logic [ENTRY_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    addr_t addr;
    logic  last;
  } patch_t;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [ADDR_W-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [ENTRY_W-1:0]  in_packed_entry;
  logic                in_end_of_table;
  logic                out_valid;
  logic                out_ready;
  logic [ADDR_W-1:0]   out_patch_address;
  logic                out_last_of_item;

  relr_relocation_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_packed_entry   (in_packed_entry),
    .in_end_of_table   (in_end_of_table),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_patch_address (out_patch_address),
    .out_last_of_item  (out_last_of_item)
  );

  always #5 clk = ~clk;

  addr_t  base_model;
  addr_t  next_word_model;
  patch_t expected_patches[$];
  int     errors = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;
  bit     hold_request = 1'b0;

  // Expand one entry into the patch addresses it produces.
  function automatic void predict_entry(input logic [ENTRY_W-1:0] entry, input logic eot);
    patch_t p;
    int     j;
    if (!entry[0]) begin
      p.addr = base_model + entry;
      p.last = 1'b1;
      expected_patches.push_back(p);
      next_word_model = p.addr + WORD_BYTES;
    end else begin
      for (j = 0; j < BITMAP_BITS; j++) begin
        if (entry[j+1]) begin
          p.addr = next_word_model + (addr_t'(j) << WORD_SHIFT);
          p.last = ((entry >> (j + 2)) == '0);
          expected_patches.push_back(p);
        end
      end
      next_word_model = next_word_model + BITMAP_STRIDE;
    end
    if (eot) next_word_model = '0;
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_offset();
    case ($urandom_range(0, 3))
      0:       return rand_word() & ~ENTRY_W'(1);
      1:       return {$urandom, $urandom} & ENTRY_W'(64'h0000_0000_00FF_FFF8);
      2:       return ALL_ONES - (ENTRY_W'($urandom_range(0, 255)) << 1) - 1;
      default: return ENTRY_W'($urandom_range(0, 1023)) << 1;
    endcase
  endfunction

  function automatic logic [ENTRY_W-1:0] rand_bitmap();
    logic [ENTRY_W-1:0] sparse;
    sparse = (ENTRY_W'(1) << $urandom_range(1, 63)) | (ENTRY_W'(1) << $urandom_range(1, 63));
    case ($urandom_range(0, 7))
      0, 1:    return rand_word() | 1;
      2, 3, 4: return sparse | 1;
      5:       return ~sparse | 1;
      6:       return rand_word() & rand_word() & rand_word() | 1;
      default: return ENTRY_W'(1);
    endcase
  endfunction

  // Offer one entry and hold it until the transfer happens.
  task automatic send_entry(input logic [ENTRY_W-1:0] entry, input logic eot, input bit gaps);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gaps && gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid        = 1'b1;
    in_packed_entry = entry;
    in_end_of_table = eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_entry(entry, eot);
    @(negedge clk);
  endtask

  // Empty bitmaps produce nothing, so let the block settle after the last result.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_patches.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_load_base(input addr_t value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    base_model = value;
  endtask

  task automatic test_leading_bitmap();
    send_entry(ENTRY_W'(64'hB), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h8000_0000_0000_0001), 1'b1, 1'b1);
  endtask

  task automatic test_offsets();
    send_entry(ENTRY_W'(0), 1'b0, 1'b1);
    send_entry(ALL_ONES, 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'hFFFF_FFFF_FFFF_FFF8), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'hFFFF_FFFF_FFFF_FFFE), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h3), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h6), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h1234_5678_9ABC_DEF2), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h5), 1'b1, 1'b1);
  endtask

  task automatic test_empty_bitmaps();
    send_entry(ENTRY_W'(64'h100), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h1), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h7), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h1), 1'b1, 1'b1);
    // table closed with no result: must still count from zero
    send_entry(ENTRY_W'(64'h3), 1'b1, 1'b1);
  endtask

  task automatic test_load_base();
    write_load_base(ALL_ONES);
    send_entry(ENTRY_W'(64'h8), 1'b0, 1'b1);
    send_entry(ENTRY_W'(64'h2000_0000_0000_0003), 1'b0, 1'b1);
    // new base mid-table: next word address carries over
    write_load_base(rand_word());
    send_entry(ENTRY_W'(64'h11), 1'b0, 1'b1);
    send_entry(rand_offset(), 1'b1, 1'b1);
    write_load_base('0);
  endtask

  task automatic test_receiver_hold();
    int k;
    hold_request = 1'b1;
    for (k = 0; k < 24; k++) begin
      if (k % 3 == 0) send_entry(rand_offset(), 1'b0, 1'b0);
      else send_entry(rand_bitmap(), k == 23, 1'b0);
    end
    drain_results();
  endtask

  task automatic test_random_tables();
    int sent;
    int len;
    int k;
    logic [ENTRY_W-1:0] entry;
    logic eot;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_load_base('0);
          1:       write_load_base(ALL_ONES);
          default: write_load_base(rand_word());
        endcase
      end
      len = $urandom_range(1, 10);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) entry = rand_word();
        else if (k == 0 && $urandom_range(0, 4) != 0) entry = rand_offset();
        else if ($urandom_range(0, 9) < 3) entry = rand_offset();
        else entry = rand_bitmap();
        // some tables run on into the next one without an end mark
        eot = (k == len - 1) && ($urandom_range(0, 4) != 0);
        send_entry(entry, eot, 1'b1);
        sent++;
      end
    end
  endtask

  // Result side: stall patterns of random length, plus the requested hold-off.
  initial begin
    rx_mode_e mode;
    int       span;
    int       tick;
    out_ready = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(negedge clk);
        if (hold_request) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_request = 1'b0;
        end
        tick++;
        case (mode)
          RX_ALWAYS:  out_ready = 1'b1;
          RX_HALF:    out_ready = $urandom_range(0, 1);
          RX_MOSTLY:  out_ready = ($urandom_range(0, 9) != 0);
          default:    out_ready = (tick % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    patch_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_patches.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected transfer, expected none, got address %h last %b",
                   $time, out_patch_address, out_last_of_item);
      end else begin
        want = expected_patches.pop_front();
        if (want.addr !== out_patch_address) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: patch_address expected %h got %h",
                     $time, want.addr, out_patch_address);
        end
        if (want.last !== out_last_of_item) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: last_of_item expected %b got %b",
                     $time, want.last, out_last_of_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_packed_entry = '0;
    in_end_of_table = 1'b0;
    base_model      = '0;
    next_word_model = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_leading_bitmap();
    test_offsets();
    test_empty_bitmaps();
    test_load_base();
    test_receiver_hold();
    test_random_tables();

    drain_results();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== relr_relocation_decoder.f =====
hdl/relr_pkg.sv
hdl/relr_datapath.sv
hdl/relr_ctrl.sv
hdl/relr_relocation_decoder.sv
sim/tb_relr_relocation_decoder.sv
